[sv/srd_pkg.sv]
// ----------------------------------------------------------------------------
// srd_pkg
// Shared types and constants of the stream record deframer: payload structs,
// mode codes, register indexes, reset values and the request passed from the
// window control to the result emitter.
// ----------------------------------------------------------------------------
package srd_pkg;

    // largest delimiter the window supports
    localparam int DELIM_MAX_DEF = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES = 2'd3;

    // split modes; the unused code behaves as line mode
    localparam logic [1:0] MODE_LINE  = 2'd0;
    localparam logic [1:0] MODE_EXACT = 2'd1;
    localparam logic [1:0] MODE_UNTIL = 2'd2;

    // register reset values
    localparam logic [1:0]  RST_MODE        = MODE_LINE;
    localparam logic [15:0] RST_RECORD_LEN  = 16'd4096;
    localparam logic [3:0]  RST_DELIM_LEN   = 4'd1;
    localparam logic [63:0] RST_DELIM_BYTES = 64'd10;

    // line mode characters
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } srd_in_t;

    // result request
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       record_end;
        logic       truncated;
    } srd_out_t;

    // one result to produce, from window control to emitter
    typedef struct packed {
        logic       valid;       // produce a result this cycle
        logic       is_byte;     // payload byte, else an end marker
        logic       last_flush;  // last byte released at stream end
        logic       flush_mark;  // marker belongs to a stream end flush
        logic [7:0] data;
    } srd_pop_t;

endpackage

[sv/srd_cell.sv]
// ----------------------------------------------------------------------------
// srd_cell
// One byte of the held window. Takes its neighbor's byte on every accepted
// request and compares its own byte against every delimiter byte.
// ----------------------------------------------------------------------------
module srd_cell
    import srd_pkg::*;
#(
    parameter int DELIM_MAX = DELIM_MAX_DEF
) (
    input  logic                      aclk,
    input  logic                      shift_en,
    input  logic [7:0]                shift_in,
    input  logic [DELIM_MAX-1:0][7:0] delim,
    output logic [7:0]                byte_out,
    output logic [DELIM_MAX-1:0]      eq_out
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // shift from the newer neighbor
    assign byte_next = shift_en ? shift_in : byte_reg;

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    // compare against each delimiter position
    always_comb begin
        for (int k = 0; k < DELIM_MAX; k++) begin
            eq_out[k] = (byte_reg == delim[k]);
        end
    end

    assign byte_out = byte_reg;

endmodule

[sv/srd_emit.sv]
// ----------------------------------------------------------------------------
// srd_emit
// Result emitter: turns one window request per cycle, while can_pop is high,
// into a result, counts the open record's bytes, holds the output register.
// ----------------------------------------------------------------------------
module srd_emit
    import srd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  srd_pop_t    req,
    input  logic [1:0]  mode,
    input  logic [15:0] record_length,
    input  logic        m_ready,
    output logic        can_pop,
    output logic        m_valid,
    output srd_out_t    m_payload
);

    logic [15:0] bir_reg;
    logic [15:0] bir_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    srd_out_t    res_reg;
    srd_out_t    res_next;

    logic [16:0] limit;
    logic [16:0] cnt;
    logic        hit;
    logic        is_exact;
    logic        trunc_mode;
    logic        emit;

    // exact mode limit, zero meaning the full 16-bit range
    assign limit      = (record_length == 16'd0) ? 17'h10000 : {1'b0, record_length};
    assign cnt        = {1'b0, bir_reg} + 17'd1;
    assign hit        = (cnt >= limit);
    assign is_exact   = (mode == MODE_EXACT);
    assign trunc_mode = (mode == MODE_EXACT) || (mode == MODE_UNTIL);

    // build the result and the new record count
    always_comb begin
        res_next = res_reg;
        bir_next = bir_reg;
        emit     = 1'b0;
        if (req.valid) begin
            if (req.is_byte) begin
                emit                = 1'b1;
                res_next            = '0;
                res_next.out_byte   = req.data;
                res_next.byte_valid = 1'b1;
                if (is_exact) begin
                    if (hit) begin
                        res_next.record_end = 1'b1;
                        bir_next            = 16'd0;
                    end else begin
                        bir_next = cnt[15:0];
                    end
                end else if (bir_reg != 16'hFFFF) begin
                    bir_next = bir_reg + 16'd1;
                end
                // stream end closes a record still open after this byte
                if (req.last_flush && !(is_exact && hit)) begin
                    res_next.record_end = 1'b1;
                    res_next.truncated  = trunc_mode;
                    bir_next            = 16'd0;
                end
            end else if (req.flush_mark) begin
                // bare close at stream end, only for an open record
                if (bir_reg != 16'd0) begin
                    emit                = 1'b1;
                    res_next            = '0;
                    res_next.record_end = 1'b1;
                    res_next.truncated  = trunc_mode;
                    bir_next            = 16'd0;
                end
            end else begin
                // delimiter or line end marker
                emit                = 1'b1;
                res_next            = '0;
                res_next.record_end = 1'b1;
                bir_next            = 16'd0;
            end
        end
    end

    // output register
    assign m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    assign can_pop      = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bir_reg     <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            bir_reg     <= bir_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = res_reg;

endmodule

[sv/stream_record_deframer_core.sv]
// ----------------------------------------------------------------------------
// stream_record_deframer_core
// Splits a byte stream into records by line end, fixed length or a delimiter
// of up to DELIM_MAX bytes; candidate delimiter bytes wait in a cell chain.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    data_byte, stream_end
//   m_       out  m_valid/m_ready    out_byte, byte_valid, record_end, truncated
//   cfg_     in   cfg_we             cfg_index, cfg_data
//
// While the receiver keeps up, a request whose step gives zero or one result
// is taken every cycle, and a step with k results (held bytes released, a
// marker) sends one result a cycle into the output register; the next
// request is taken in the cycle its last result is loaded into the output
// register. Synchronous active low reset clears counts and flags; window
// bytes are not cleared. After stream end all requests are taken and dropped
// until reset.
// ----------------------------------------------------------------------------
module stream_record_deframer_core
    import srd_pkg::*;
#(
    parameter int DELIM_MAX = DELIM_MAX_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  srd_in_t               s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output srd_out_t              m_payload,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NCELL = DELIM_MAX + 1;
    localparam int CW    = $clog2(NCELL + 1);
    localparam int PW    = $clog2(NCELL);

    // configuration registers
    logic [1:0]  mode_reg;
    logic [15:0] rec_len_reg;
    logic [3:0]  dlen_reg;
    logic [63:0] delim_reg;

    // window control
    logic [CW-1:0] held_reg, held_next;
    logic [CW-1:0] rel_reg, rel_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic          marker_reg, marker_next;
    logic          flush_reg, flush_next;
    logic          closed_reg, closed_next;

    logic [DELIM_MAX-1:0][7:0] delim;
    logic [NCELL-1:0][7:0]     cell_byte;
    logic [NCELL-1:0][DELIM_MAX-1:0] cell_eq;
    logic [DELIM_MAX-1:0]      eqb;

    logic          s_acc;
    logic          take;
    logic          pending;
    logic          last_one;
    logic          can_pop;
    logic          pop_go;
    logic [7:0]    b;
    logic [CW-1:0] len;
    logic [CW-1:0] dlen;
    logic [CW-1:0] smax;
    logic [CW-1:0] s_len;
    logic          hold_cr;
    srd_pop_t      req;

    // delimiter bytes, zero past the eighth
    genvar k;
    generate
        for (k = 0; k < DELIM_MAX; k++) begin : g_delim
            if (k < 8) begin : g_byte
                assign delim[k] = delim_reg[8*k +: 8];
            end else begin : g_zero
                assign delim[k] = 8'h00;
            end
        end
    endgenerate

    // handshake
    assign pending  = (rel_reg != '0) || marker_reg;
    assign last_one = ((rel_reg == CW'(1)) && !marker_reg) || ((rel_reg == '0) && marker_reg);
    assign pop_go   = pending && can_pop;
    assign s_ready  = closed_reg || !pending || (last_one && can_pop);
    assign s_acc    = s_valid && s_ready;
    assign take     = s_acc && !closed_reg;
    assign b        = s_payload.data_byte;

    // cell chain, newest byte in cell 0
    genvar j;
    generate
        for (j = 0; j < NCELL; j++) begin : g_cell
            logic [7:0] sin;
            if (j == 0) begin : g_head
                assign sin = b;
            end else begin : g_link
                assign sin = cell_byte[j-1];
            end
            srd_cell #(
                .DELIM_MAX (DELIM_MAX)
            ) u_cell (
                .aclk     (aclk),
                .shift_en (take),
                .shift_in (sin),
                .delim    (delim),
                .byte_out (cell_byte[j]),
                .eq_out   (cell_eq[j])
            );
        end
    endgenerate

    // incoming byte against each delimiter position
    always_comb begin
        for (int i = 0; i < DELIM_MAX; i++) begin
            eqb[i] = (b == delim[i]);
        end
    end

    // clamped delimiter length and window length
    always_comb begin
        if (dlen_reg == 4'd0) begin
            dlen = CW'(1);
        end else if (32'(dlen_reg) > DELIM_MAX) begin
            dlen = CW'(DELIM_MAX);
        end else begin
            dlen = CW'(dlen_reg);
        end
    end

    assign len  = held_reg + CW'(1);
    assign smax = (len < dlen) ? len : dlen;

    // longest window suffix that is a delimiter prefix
    always_comb begin
        logic ok;
        s_len = '0;
        for (int s = 1; s <= DELIM_MAX; s++) begin
            ok = (CW'(s) <= smax);
            for (int p = 0; p < s; p++) begin
                if (p == 0) begin
                    ok = ok && eqb[s-1];
                end else begin
                    ok = ok && cell_eq[p-1][s-1-p];
                end
            end
            if (ok) begin
                s_len = CW'(s);
            end
        end
    end

    assign hold_cr = (held_reg != '0) && (cell_byte[0] == CH_CR);

    // plan of the next step and drain of the current one
    always_comb begin
        held_next   = held_reg;
        rel_next    = rel_reg;
        ptr_next    = ptr_reg;
        marker_next = marker_reg;
        flush_next  = flush_reg;
        closed_next = closed_reg;
        if (pop_go) begin
            if (rel_reg != '0) begin
                rel_next = rel_reg - CW'(1);
                ptr_next = ptr_reg - PW'(1);
            end else begin
                marker_next = 1'b0;
            end
        end
        if (take) begin
            ptr_next    = PW'(held_reg);
            marker_next = 1'b0;
            flush_next  = 1'b0;
            held_next   = '0;
            if (s_payload.stream_end) begin
                closed_next = 1'b1;
                flush_next  = 1'b1;
                rel_next    = held_reg;
                marker_next = (held_reg == '0);
            end else begin
                case (mode_reg)
                    MODE_EXACT: begin
                        rel_next = len;
                    end
                    MODE_UNTIL: begin
                        rel_next = len - s_len;
                        if (s_len == dlen) begin
                            marker_next = 1'b1;
                        end else begin
                            held_next = s_len;
                        end
                    end
                    default: begin
                        if (b == CH_LF) begin
                            rel_next    = hold_cr ? (held_reg - CW'(1)) : held_reg;
                            marker_next = 1'b1;
                        end else if (b == CH_CR) begin
                            rel_next  = held_reg;
                            held_next = CW'(1);
                        end else begin
                            rel_next = len;
                        end
                    end
                endcase
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg   <= '0;
            rel_reg    <= '0;
            ptr_reg    <= '0;
            marker_reg <= 1'b0;
            flush_reg  <= 1'b0;
            closed_reg <= 1'b0;
        end else begin
            held_reg   <= held_next;
            rel_reg    <= rel_next;
            ptr_reg    <= ptr_next;
            marker_reg <= marker_next;
            flush_reg  <= flush_next;
            closed_reg <= closed_next;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= RST_MODE;
            rec_len_reg <= RST_RECORD_LEN;
            dlen_reg    <= RST_DELIM_LEN;
            delim_reg   <= RST_DELIM_BYTES;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MODE:        mode_reg    <= cfg_data[1:0];
                REG_RECORD_LEN:  rec_len_reg <= cfg_data[15:0];
                REG_DELIM_LEN:   dlen_reg    <= cfg_data[3:0];
                REG_DELIM_BYTES: delim_reg   <= cfg_data[63:0];
                default: begin
                end
            endcase
        end
    end

    // next result, oldest released byte first
    always_comb begin
        req            = '0;
        req.valid      = pop_go;
        req.is_byte    = (rel_reg != '0);
        req.last_flush = flush_reg && (rel_reg == CW'(1));
        req.flush_mark = flush_reg;
        req.data       = cell_byte[ptr_reg];
    end

    srd_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req           (req),
        .mode          (mode_reg),
        .record_length (rec_len_reg),
        .m_ready       (m_ready),
        .can_pop       (can_pop),
        .m_valid       (m_valid),
        .m_payload     (m_payload)
    );

endmodule

[tb/sv/tb_stream_record_deframer_core.sv]
// ----------------------------------------------------------------------------
// tb_stream_record_deframer_core
// Self-checking testbench for the stream record deframer. A behavioral
// model of the line, exact length and until delimiter splitting predicts
// every result request; a checker compares each accepted result with the
// oldest prediction. Directed requests cover the corner cases, then random
// phases run each mode under several sender and receiver idling profiles,
// and the run closes with a single stream end flush.
// ----------------------------------------------------------------------------
module tb_stream_record_deframer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import srd_pkg::*;

    // unused mode code, decoded as line mode
    localparam logic [1:0] MODE_ALIAS_LINE = 2'd3;
    // idle cycles allowed after the last result before a register write
    localparam int SETTLE_CYCLES = 16;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    srd_in_t               s_payload = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    srd_out_t              m_payload;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int ready_hold    = 0;
    int err_count     = 0;

    // predicted result requests, oldest first
    srd_out_t pending_results[$];

    // model registers and state
    logic [1:0]  mdl_mode;
    logic [15:0] mdl_rec_len;
    logic [3:0]  mdl_dlen;
    logic [63:0] mdl_delim;
    logic [7:0]  held_bytes [0:DELIM_MAX_DEF];
    int unsigned held_cnt;
    int unsigned rec_fill;
    bit          closed_flag;

    stream_record_deframer_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // behavioral model
    // ------------------------------------------------------------------

    function automatic void clear_model();
        mdl_mode    = RST_MODE;
        mdl_rec_len = RST_RECORD_LEN;
        mdl_dlen    = RST_DELIM_LEN;
        mdl_delim   = RST_DELIM_BYTES;
        for (int i = 0; i <= DELIM_MAX_DEF; i++) begin
            held_bytes[i] = 8'h00;
        end
        held_cnt    = 0;
        rec_fill    = 0;
        closed_flag = 1'b0;
        pending_results.delete();
    endfunction

    function automatic void load_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_MODE:        mdl_mode    = data[1:0];
            REG_RECORD_LEN:  mdl_rec_len = data[15:0];
            REG_DELIM_LEN:   mdl_dlen    = data[3:0];
            REG_DELIM_BYTES: mdl_delim   = data;
            default: ;
        endcase
    endfunction

    function automatic void push_result(input logic [7:0] b, input logic v,
                                        input logic e, input logic t);
        srd_out_t r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.record_end = e;
        r.truncated  = t;
        pending_results.push_back(r);
    endfunction

    // one payload byte; exact mode closes the record at its limit
    function automatic void pass_byte(input logic [7:0] b);
        int unsigned limit;
        if (mdl_mode == MODE_EXACT) begin
            limit = (mdl_rec_len == 16'd0) ? 65536 : mdl_rec_len;
            if (rec_fill + 1 >= limit) begin
                push_result(b, 1'b1, 1'b1, 1'b0);
                rec_fill = 0;
            end else begin
                push_result(b, 1'b1, 1'b0, 1'b0);
                rec_fill++;
            end
        end else begin
            push_result(b, 1'b1, 1'b0, 1'b0);
            if (rec_fill < 65535) rec_fill++;
        end
    endfunction

    // bare end marker after a delimiter
    function automatic void close_record();
        push_result(8'h00, 1'b0, 1'b1, 1'b0);
        rec_fill = 0;
    endfunction

    function automatic void release_held(input int unsigned cnt);
        for (int unsigned i = 0; i < cnt && i <= DELIM_MAX_DEF; i++) begin
            pass_byte(held_bytes[i]);
        end
    endfunction

    function automatic logic [7:0] delim_at(input int i);
        return (i < 8) ? mdl_delim[8*i +: 8] : 8'h00;
    endfunction

    // line mode: LF ends, CR directly before it is dropped
    function automatic void line_step(input logic [7:0] b);
        int unsigned keep;
        if (b == CH_LF) begin
            keep = held_cnt;
            if (keep > 0 && held_bytes[keep-1] == CH_CR) keep--;
            release_held(keep);
            held_cnt = 0;
            close_record();
        end else begin
            release_held(held_cnt);
            held_cnt = 0;
            if (b == CH_CR) begin
                held_bytes[0] = b;
                held_cnt      = 1;
            end else begin
                pass_byte(b);
            end
        end
    endfunction

    // until mode: longest delimiter prefix at the window tail stays held
    function automatic void until_step(input logic [7:0] b);
        logic [7:0] win [0:DELIM_MAX_DEF];
        int dlen, len, smax, s, i;
        bit hit;
        dlen = int'(mdl_dlen);
        if (dlen == 0) dlen = 1;
        if (dlen > DELIM_MAX_DEF) dlen = DELIM_MAX_DEF;
        len = (held_cnt > DELIM_MAX_DEF) ? DELIM_MAX_DEF : held_cnt;
        for (i = 0; i < len; i++) win[i] = held_bytes[i];
        win[len] = b;
        len++;
        smax = (len < dlen) ? len : dlen;
        s    = smax;
        hit  = 1'b0;
        while (s > 0 && !hit) begin
            hit = 1'b1;
            for (i = 0; i < s; i++) begin
                if (win[len-s+i] != delim_at(i)) hit = 1'b0;
            end
            if (!hit) s--;
        end
        for (i = 0; i < len - s; i++) pass_byte(win[i]);
        if (s == dlen) begin
            held_cnt = 0;
            close_record();
        end else begin
            for (i = 0; i < s; i++) held_bytes[i] = win[len-s+i];
            held_cnt = s;
        end
    endfunction

    function automatic void deframe_step(input srd_in_t req);
        int unsigned before_n;
        srd_out_t    tail;
        logic        trunc;
        if (closed_flag) return;
        if (req.stream_end) begin
            closed_flag = 1'b1;
            before_n    = pending_results.size();
            release_held(held_cnt);
            held_cnt = 0;
            if (rec_fill > 0) begin
                trunc = (mdl_mode == MODE_EXACT || mdl_mode == MODE_UNTIL);
                if (pending_results.size() > before_n) begin
                    tail            = pending_results.pop_back();
                    tail.record_end = 1'b1;
                    tail.truncated  = trunc;
                    pending_results.push_back(tail);
                end else begin
                    push_result(8'h00, 1'b0, 1'b1, trunc);
                end
                rec_fill = 0;
            end
        end else if (mdl_mode == MODE_EXACT) begin
            release_held(held_cnt);
            held_cnt = 0;
            pass_byte(req.data_byte);
        end else if (mdl_mode == MODE_UNTIL) begin
            until_step(req.data_byte);
        end else begin
            line_step(req.data_byte);
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input srd_out_t got,
                                   input srd_out_t want);
        err_count++;
        $display("%0t %s: got %02h/%b/%b/%b want %02h/%b/%b/%b", $realtime, what,
                 got.out_byte, got.byte_valid, got.record_end, got.truncated,
                 want.out_byte, want.byte_valid, want.record_end, want.truncated);
    endtask

    task automatic check_result(input srd_out_t got);
        srd_out_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", got, '0);
        end else begin
            want = pending_results.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.record_end !== want.record_end || got.truncated !== want.truncated) begin
                report_mismatch("result mismatch", got, want);
            end
        end
    endtask

    // model update and result check, one place per rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_model();
        end else begin
            if (cfg_we) load_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) deframe_step(s_payload);
            if (m_valid && m_ready) check_result(m_payload);
        end
    end

    // receiver: long hold-off on request, else random stalls
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic send_req(input logic [7:0] data, input logic last);
        srd_in_t req;
        req.data_byte  = data;
        req.stream_end = last;
        @(negedge aclk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // stop sending, drain all predicted results, let the block go idle
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [7:0] line_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) return CH_LF;
        if (pick < 30) return CH_CR;
        return 8'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // line mode with reset settings: byte extremes, CRLF, bare LF, lone CR
    task automatic test_line_directed();
        send_req(8'h00, 1'b0);
        send_req(8'hFF, 1'b0);
        send_req(CH_CR, 1'b0);
        send_req(CH_LF, 1'b0);
        send_req(CH_LF, 1'b0);
        send_req(CH_CR, 1'b0);
        send_req(CH_CR, 1'b0);
        send_req(8'h7A, 1'b0);
        // left held, released by the first exact mode byte below
        send_req(CH_CR, 1'b0);
    endtask

    // exact mode: length one, limit lowered mid record, zero and max length
    task automatic test_exact_directed();
        settle();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_EXACT));
        write_reg(REG_RECORD_LEN, 64'd1);
        send_req(8'h41, 1'b0);
        settle();
        write_reg(REG_RECORD_LEN, 64'd4);
        send_req(8'h01, 1'b0);
        send_req(8'h02, 1'b0);
        send_req(8'h03, 1'b0);
        settle();
        write_reg(REG_RECORD_LEN, 64'd2);
        send_req(8'h04, 1'b0);
        settle();
        write_reg(REG_RECORD_LEN, 64'd0);
        send_req(8'h55, 1'b0);
        settle();
        write_reg(REG_RECORD_LEN, 64'd65535);
        send_req(8'hAA, 1'b0);
    endtask

    // until mode: overlapping partial match, length zero and oversize,
    // held bytes carried into the alias line mode
    task automatic test_until_directed();
        settle();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_UNTIL));
        write_reg(REG_DELIM_LEN, 64'd3);
        write_reg(REG_DELIM_BYTES, 64'h626161);
        send_req(8'h61, 1'b0);
        send_req(8'h61, 1'b0);
        send_req(8'h61, 1'b0);
        send_req(8'h62, 1'b0);
        settle();
        write_reg(REG_DELIM_LEN, 64'd0);
        write_reg(REG_DELIM_BYTES, 64'h0);
        send_req(8'h00, 1'b0);
        settle();
        write_reg(REG_DELIM_LEN, 64'd15);
        write_reg(REG_DELIM_BYTES, {CFG_DATA_W{1'b1}});
        send_req(8'hFF, 1'b0);
        send_req(8'hFF, 1'b0);
        settle();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_ALIAS_LINE));
        send_req(CH_LF, 1'b0);
    endtask

    // one random phase: fresh settings for the mode, then well-formed traffic
    task automatic run_phase(input logic [1:0] mode_sel, input int snd, input int rcv,
                             input int hold, input int n_items);
        logic [15:0] rec_len;
        logic [3:0]  dlen;
        logic [63:0] delim;
        bit          narrow;
        int          dl_eff, sent, pick, k, i;
        settle();
        @(posedge aclk);
        snd_idle_pct  = snd;
        rcv_stall_pct = rcv;
        ready_hold    = hold;
        narrow        = $urandom_range(0, 1);
        delim         = '0;
        dl_eff        = 1;
        case (mode_sel)
            MODE_EXACT: begin
                pick = $urandom_range(0, 99);
                if (pick < 70)      rec_len = 16'($urandom_range(1, 6));
                else if (pick < 80) rec_len = 16'd65535;
                else if (pick < 90) rec_len = 16'd0;
                else                rec_len = 16'($urandom);
                write_reg(REG_MODE, CFG_DATA_W'(MODE_EXACT));
                write_reg(REG_RECORD_LEN, CFG_DATA_W'(rec_len));
            end
            MODE_UNTIL: begin
                pick = $urandom_range(0, 99);
                if (pick < 80)      dlen = 4'($urandom_range(1, 8));
                else if (pick < 90) dlen = 4'd0;
                else                dlen = 4'($urandom_range(9, 15));
                for (i = 0; i < 8; i++) begin
                    delim[8*i +: 8] = narrow ? 8'($urandom_range(0, 2)) : 8'($urandom);
                end
                dl_eff = (dlen == 0) ? 1 : (dlen > DELIM_MAX_DEF) ? DELIM_MAX_DEF : int'(dlen);
                write_reg(REG_MODE, CFG_DATA_W'(MODE_UNTIL));
                write_reg(REG_DELIM_LEN, CFG_DATA_W'(dlen));
                write_reg(REG_DELIM_BYTES, delim);
            end
            default: begin
                write_reg(REG_MODE, ($urandom_range(0, 3) == 0) ?
                          CFG_DATA_W'(MODE_ALIAS_LINE) : CFG_DATA_W'(MODE_LINE));
            end
        endcase
        sent = 0;
        while (sent < n_items) begin
            if (mode_sel == MODE_UNTIL) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    // full delimiter or a prefix of it
                    k = (pick < 30) ? dl_eff : $urandom_range(1, dl_eff);
                    for (i = 0; i < k; i++) send_req(delim[8*i +: 8], 1'b0);
                    sent += k;
                end else begin
                    send_req(narrow ? 8'($urandom_range(0, 3)) : 8'($urandom), 1'b0);
                    sent++;
                end
            end else if (mode_sel == MODE_EXACT) begin
                send_req(8'($urandom), 1'b0);
                sent++;
            end else begin
                send_req(line_byte(), 1'b0);
                sent++;
            end
        end
    endtask

    // every mode under each idling profile; first exact phase holds off output
    task automatic test_random_phases();
        int snd_tab [4] = '{0, 63, 0, 30};
        int rcv_tab [4] = '{0, 0, 63, 30};
        for (int p = 0; p < 4; p++) begin
            run_phase(MODE_LINE,  snd_tab[p], rcv_tab[p], 0, 32);
            run_phase(MODE_EXACT, snd_tab[p], rcv_tab[p], (p == 0) ? 200 : 0, 32);
            run_phase(MODE_UNTIL, snd_tab[p], rcv_tab[p], 0, 32);
        end
    endtask

    // stream end with a held delimiter byte, then requests that are dropped
    task automatic test_stream_end();
        settle();
        @(posedge aclk);
        snd_idle_pct  = 30;
        rcv_stall_pct = 30;
        write_reg(REG_MODE, CFG_DATA_W'(MODE_UNTIL));
        write_reg(REG_DELIM_LEN, 64'd2);
        write_reg(REG_DELIM_BYTES, CFG_DATA_W'({CH_LF, CH_CR}));
        send_req(8'h71, 1'b0);
        send_req(CH_CR, 1'b0);
        send_req(8'($urandom), 1'b1);
        send_req(8'($urandom), 1'b0);
        send_req(8'($urandom), 1'b1);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_line_directed();
        test_exact_directed();
        test_until_directed();
        test_random_phases();
        test_stream_end();
        settle();
        repeat (32) @(negedge aclk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hang guard
    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
sv/srd_pkg.sv
sv/srd_cell.sv
sv/srd_emit.sv
sv/stream_record_deframer_core.sv
tb/sv/tb_stream_record_deframer_core.sv
